// ===== rtl/core/plid_pkg.sv =====
// Shared types and constants for the positional linked list block.
`timescale 1ns / 1ps
package plid_pkg;

  // Default node pool size
  localparam int CapacityDef = 64;

  // Field widths fixed by the interface
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int LEN_W    = 7;
  localparam int STATUS_W = 2;

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TAKE,
    ST_PLACE,
    ST_WALK,
    ST_WALK_WAIT,
    ST_NEXT_WAIT,
    ST_LINK_PREV,
    ST_VIC_RD,
    ST_FREE_VIC,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                    req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                 status;
    logic signed [VAL_W-1:0] removed_value;
    logic [LEN_W-1:0]        list_length;
  } rsp_t;

  // Memory strobes from the sequencer to the node store
  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic elem_we;
  } mem_en_t;

endpackage

// ===== rtl/core/plid_store.sv =====
// Node pool: element memory and next-pointer memory, registered read.
`timescale 1ns / 1ps
module plid_store #(
  parameter int CAPACITY = plid_pkg::CapacityDef
) (
  input  logic                                  clk_i,
  input  plid_pkg::mem_en_t                     en_i,
  input  logic [$clog2(CAPACITY)-1:0]           rd_addr_i,
  input  logic [$clog2(CAPACITY)-1:0]           link_waddr_i,
  input  logic [$clog2(CAPACITY+1)-1:0]         link_wdata_i,
  input  logic [$clog2(CAPACITY)-1:0]           elem_waddr_i,
  input  logic signed [plid_pkg::VAL_W-1:0]     elem_wdata_i,
  output logic [$clog2(CAPACITY+1)-1:0]         link_rdata_o,
  output logic signed [plid_pkg::VAL_W-1:0]     elem_rdata_o
);
  import plid_pkg::*;

  localparam int PW = $clog2(CAPACITY + 1);

  logic [PW-1:0]           link_mem [CAPACITY];
  logic signed [VAL_W-1:0] elem_mem [CAPACITY];

  // Link memory port
  always_ff @(posedge clk_i) begin
    if (en_i.link_we) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    if (en_i.rd_en) begin
      link_rdata_o <= link_mem[rd_addr_i];
    end
  end

  // Element memory port, read at the same address as the links
  always_ff @(posedge clk_i) begin
    if (en_i.elem_we) begin
      elem_mem[elem_waddr_i] <= elem_wdata_i;
    end
    if (en_i.rd_en) begin
      elem_rdata_o <= elem_mem[rd_addr_i];
    end
  end

endmodule

// ===== rtl/core/plid_ctrl.sv =====
// Request sequencer: range checks, node allocation, chain walk and splice.
`timescale 1ns / 1ps
module plid_ctrl #(
  parameter int CAPACITY = plid_pkg::CapacityDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  plid_pkg::req_t                        in_req_i,
  output logic                                  rsp_valid_o,
  input  logic                                  rsp_ready_i,
  output plid_pkg::rsp_t                        rsp_o,
  output plid_pkg::mem_en_t                     mem_en_o,
  output logic [$clog2(CAPACITY)-1:0]           rd_addr_o,
  output logic [$clog2(CAPACITY)-1:0]           link_waddr_o,
  output logic [$clog2(CAPACITY+1)-1:0]         link_wdata_o,
  output logic [$clog2(CAPACITY)-1:0]           elem_waddr_o,
  output logic signed [plid_pkg::VAL_W-1:0]     elem_wdata_o,
  input  logic [$clog2(CAPACITY+1)-1:0]         link_rdata_i,
  input  logic signed [plid_pkg::VAL_W-1:0]     elem_rdata_i
);
  import plid_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int LW = ((PW > POS_W) ? PW : POS_W) + 1;
  localparam int KW = POS_W + 1;
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  state_e state_q, state_d;

  // Control state
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] free_q, free_d;
  logic [PW-1:0] unused_q, unused_d;
  logic [PW-1:0] count_q, count_d;

  // Per-request working registers
  logic                    op_q, op_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [PW-1:0]           cur_q, cur_d;
  logic [PW-1:0]           node_q, node_d;
  logic [POS_W-1:0]        k_q, k_d;
  status_e                 status_q, status_d;
  logic signed [VAL_W-1:0] removed_q, removed_d;

  logic [LW-1:0] pos_ext, cnt_ext;
  logic          ins_bad, del_bad, pos_one;
  logic [PW-1:0] link_sat;
  logic          walk_more, walk_more_next;

  // Range checks and link clamping
  assign pos_ext  = LW'(pos_q);
  assign cnt_ext  = LW'(count_q);
  assign pos_one  = (pos_q == POS_W'(1));
  assign ins_bad  = (pos_q == '0) || (pos_ext > LW'(cnt_ext + LW'(1)));
  assign del_bad  = (pos_q == '0) || (pos_ext > cnt_ext);
  assign link_sat = (link_rdata_i >= NIL) ? NIL : link_rdata_i;
  // Walk continues while step k+1 is short of the predecessor position
  assign walk_more      = (KW'(KW'(k_q) + KW'(1)) < KW'(pos_q)) && (cur_q != NIL);
  assign walk_more_next = (KW'(KW'(k_q) + KW'(2)) < KW'(pos_q)) && (link_sat != NIL);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign rsp_valid_o = (state_q == ST_FINISH);
  assign rsp_o.status        = status_q;
  assign rsp_o.removed_value = removed_q;
  assign rsp_o.list_length   = LEN_W'(cnt_ext);

  assign elem_waddr_o = node_q[AW-1:0];
  assign elem_wdata_o = val_q;

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= NIL;
      free_q   <= NIL;
      unused_q <= '0;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      free_q   <= free_d;
      unused_q <= unused_d;
      count_q  <= count_d;
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    cur_q     <= cur_d;
    node_q    <= node_d;
    k_q       <= k_d;
    status_q  <= status_d;
    removed_q <= removed_d;
  end

  // Next state and memory commands
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    free_d    = free_q;
    unused_d  = unused_q;
    count_d   = count_q;
    op_d      = op_q;
    pos_d     = pos_q;
    val_d     = val_q;
    cur_d     = cur_q;
    node_d    = node_q;
    k_d       = k_q;
    status_d  = status_q;
    removed_d = removed_q;

    mem_en_o     = '0;
    rd_addr_o    = cur_q[AW-1:0];
    link_waddr_o = node_q[AW-1:0];
    link_wdata_o = head_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d      = in_req_i.req_type;
          pos_d     = in_req_i.position;
          val_d     = in_req_i.value;
          status_d  = STATUS_OK;
          removed_d = '0;
          state_d   = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (op_q == REQ_INSERT) begin
          if (ins_bad) begin
            status_d = STATUS_RANGE;
            state_d  = ST_FINISH;
          end else if (free_q != NIL) begin
            // reuse the most recently freed node
            node_d          = free_q;
            mem_en_o.rd_en  = 1'b1;
            rd_addr_o       = free_q[AW-1:0];
            state_d         = ST_TAKE;
          end else if (unused_q < NIL) begin
            node_d   = unused_q;
            unused_d = PW'(unused_q + PW'(1));
            state_d  = ST_PLACE;
          end else begin
            status_d = STATUS_FULL;
            state_d  = ST_FINISH;
          end
        end else begin
          if (del_bad) begin
            status_d = STATUS_RANGE;
            state_d  = ST_FINISH;
          end else if (pos_one) begin
            node_d = head_q;
            if (head_q == NIL) begin
              count_d = PW'(count_q - PW'(1));
              state_d = ST_FINISH;
            end else begin
              mem_en_o.rd_en = 1'b1;
              rd_addr_o      = head_q[AW-1:0];
              state_d        = ST_VIC_RD;
            end
          end else begin
            cur_d   = head_q;
            k_d     = POS_W'(1);
            state_d = ST_WALK;
          end
        end
      end

      ST_TAKE: begin
        free_d  = link_sat;
        state_d = ST_PLACE;
      end

      ST_PLACE: begin
        mem_en_o.elem_we = 1'b1;
        if (pos_one) begin
          mem_en_o.link_we = 1'b1;
          link_waddr_o     = node_q[AW-1:0];
          link_wdata_o     = head_q;
          head_d           = node_q;
          count_d          = PW'(count_q + PW'(1));
          state_d          = ST_FINISH;
        end else begin
          cur_d   = head_q;
          k_d     = POS_W'(1);
          state_d = ST_WALK;
        end
      end

      ST_WALK: begin
        if (walk_more) begin
          mem_en_o.rd_en = 1'b1;
          rd_addr_o      = cur_q[AW-1:0];
          state_d        = ST_WALK_WAIT;
        end else if (cur_q == NIL) begin
          // predecessor missing: chain ended early
          if (op_q == REQ_INSERT) begin
            mem_en_o.link_we = 1'b1;
            link_waddr_o     = node_q[AW-1:0];
            link_wdata_o     = NIL;
            count_d          = PW'(count_q + PW'(1));
          end else begin
            count_d = PW'(count_q - PW'(1));
          end
          state_d = ST_FINISH;
        end else begin
          // fetch successor of the predecessor
          mem_en_o.rd_en = 1'b1;
          rd_addr_o      = cur_q[AW-1:0];
          state_d        = ST_NEXT_WAIT;
        end
      end

      ST_WALK_WAIT: begin
        // one link per cycle: next address comes straight from read data
        cur_d = link_sat;
        k_d   = POS_W'(k_q + POS_W'(1));
        if (walk_more_next) begin
          mem_en_o.rd_en = 1'b1;
          rd_addr_o      = link_sat[AW-1:0];
        end else begin
          state_d = ST_WALK;
        end
      end

      ST_NEXT_WAIT: begin
        if (op_q == REQ_INSERT) begin
          mem_en_o.link_we = 1'b1;
          link_waddr_o     = node_q[AW-1:0];
          link_wdata_o     = link_sat;
          state_d          = ST_LINK_PREV;
        end else begin
          node_d = link_sat;
          if (link_sat == NIL) begin
            count_d = PW'(count_q - PW'(1));
            state_d = ST_FINISH;
          end else begin
            mem_en_o.rd_en = 1'b1;
            rd_addr_o      = link_sat[AW-1:0];
            state_d        = ST_VIC_RD;
          end
        end
      end

      ST_LINK_PREV: begin
        mem_en_o.link_we = 1'b1;
        link_waddr_o     = cur_q[AW-1:0];
        link_wdata_o     = node_q;
        count_d          = PW'(count_q + PW'(1));
        state_d          = ST_FINISH;
      end

      ST_VIC_RD: begin
        removed_d = elem_rdata_i;
        if (pos_one) begin
          head_d = link_sat;
        end else begin
          mem_en_o.link_we = 1'b1;
          link_waddr_o     = cur_q[AW-1:0];
          link_wdata_o     = link_sat;
        end
        state_d = ST_FREE_VIC;
      end

      ST_FREE_VIC: begin
        // push victim onto the free chain
        mem_en_o.link_we = 1'b1;
        link_waddr_o     = node_q[AW-1:0];
        link_wdata_o     = free_q;
        free_d           = node_q;
        count_d          = PW'(count_q - PW'(1));
        state_d          = ST_FINISH;
      end

      ST_FINISH: begin
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/positional_list_insert_delete.sv =====
// Top level of the positional linked list: sequencer, node pool, result register.
//
// Ordered list of signed 32-bit elements held in a pool of CAPACITY nodes.
// Input channel (in_valid_i / in_ready_o / in_req_i): one request per transfer,
// insert before a one-based position or delete at a position.
// Output channel (out_valid_o / out_ready_i / out_rsp_o): exactly one result
// per request, in request order: status, removed value, list length.
// A range error or full pool is reported straight after the check. Position
// one needs no walk; any other position walks the chain from the head, which
// reads one link per cycle through the link memory's registered port.
// One request is in work at a time; the next input transfer is taken once
// the result has moved into the output register, in the cycle after at the
// earliest.
// Reset: asynchronous, active low; the list is empty, nothing is freed and
// no pool node is in use. The memories need no clearing pass.
// When the receiver stalls, the result waits in the output register and the
// sequencer holds its finished result until that register frees up.
`timescale 1ns / 1ps
module positional_list_insert_delete #(
  parameter int CAPACITY = plid_pkg::CapacityDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  plid_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output plid_pkg::rsp_t  out_rsp_o
);
  import plid_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);

  mem_en_t                 mem_en;
  logic [AW-1:0]           rd_addr, link_waddr, elem_waddr;
  logic [PW-1:0]           link_wdata, link_rdata;
  logic signed [VAL_W-1:0] elem_wdata, elem_rdata;

  logic rsp_valid, rsp_ready;
  rsp_t rsp;

  logic out_valid_q;
  rsp_t out_rsp_q;

  plid_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp),
    .mem_en_o    (mem_en),
    .rd_addr_o   (rd_addr),
    .link_waddr_o(link_waddr),
    .link_wdata_o(link_wdata),
    .elem_waddr_o(elem_waddr),
    .elem_wdata_o(elem_wdata),
    .link_rdata_i(link_rdata),
    .elem_rdata_i(elem_rdata)
  );

  plid_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk_i       (clk_i),
    .en_i        (mem_en),
    .rd_addr_i   (rd_addr),
    .link_waddr_i(link_waddr),
    .link_wdata_i(link_wdata),
    .elem_waddr_i(elem_waddr),
    .elem_wdata_i(elem_wdata),
    .link_rdata_o(link_rdata),
    .elem_rdata_o(elem_rdata)
  );

  // Output register: loads when empty or draining this cycle
  assign rsp_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Sequencer is busy right after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again while a request is in work");

  // Finished result holds until the output register takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("sequencer result dropped or changed while stalled");

  // Failed requests never report a removed element
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status != STATUS_OK) |-> (out_rsp_o.removed_value == '0))
    else $error("removed value on a failed request");

  // Pool full is only reported with every node in the list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == STATUS_FULL) |->
      (out_rsp_o.list_length == LEN_W'(CAPACITY)))
    else $error("pool full reported below capacity");

endmodule

// ===== tb/plid_checker.sv =====
// Checker for the positional linked list: watches both channels, predicts and compares results.
`timescale 1ns / 1ps
module plid_checker #(
  parameter int CAPACITY = plid_pkg::CapacityDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  plid_pkg::req_t in_req_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  plid_pkg::rsp_t out_rsp_i,
  output int             fail_count_o,
  output int             outstanding_o
);
  import plid_pkg::*;

  // Null link marker, one past the last pool node
  localparam int unsigned NIL = CAPACITY;

  // Shadow copy of the node pool and its bookkeeping
  logic signed [VAL_W-1:0] node_val  [CAPACITY];
  int unsigned             node_next [CAPACITY];
  int unsigned             head_node;
  int unsigned             free_head;
  int unsigned             fresh_used;
  int unsigned             elem_count;

  // Results still owed by the block, oldest first
  rsp_t list_replies_q [$];

  // Follow one link; anything outside the pool reads as null
  function automatic int unsigned link_after(input int unsigned n);
    if (n >= NIL) return NIL;
    return (node_next[n] >= NIL) ? NIL : node_next[n];
  endfunction

  // Node at one-based position p, walking from the head
  function automatic int unsigned node_at_pos(input int unsigned p);
    int unsigned n;
    n = (head_node >= NIL) ? NIL : head_node;
    for (int unsigned k = 1; k < p && n != NIL; k++) n = link_after(n);
    return n;
  endfunction

  // Apply one request to the shadow list and return the result it owes
  function automatic rsp_t apply_list_request(input req_t r);
    rsp_t        res;
    int unsigned pos;
    int unsigned n;
    int unsigned prev;
    int unsigned victim;
    pos               = r.position;
    res.status        = STATUS_OK;
    res.removed_value = '0;
    if (r.req_type == REQ_INSERT) begin
      if (pos < 1 || pos > elem_count + 1) begin
        res.status = STATUS_RANGE;
      end else begin
        // freed nodes go out last-in first-out, ahead of fresh pool space
        n = NIL;
        if (free_head < NIL) begin
          n         = free_head;
          free_head = link_after(n);
        end else if (fresh_used < NIL) begin
          n = fresh_used;
          fresh_used++;
        end
        if (n == NIL) begin
          res.status = STATUS_FULL;
        end else begin
          node_val[n] = r.value;
          if (pos == 1) begin
            node_next[n] = (head_node >= NIL) ? NIL : head_node;
            head_node    = n;
          end else begin
            prev = node_at_pos(pos - 1);
            if (prev == NIL) begin
              node_next[n] = NIL;
            end else begin
              node_next[n]    = link_after(prev);
              node_next[prev] = n;
            end
          end
          elem_count++;
        end
      end
    end else begin
      if (pos < 1 || pos > elem_count) begin
        res.status = STATUS_RANGE;
      end else begin
        if (pos == 1) begin
          victim = (head_node >= NIL) ? NIL : head_node;
          if (victim != NIL) head_node = link_after(victim);
        end else begin
          prev   = node_at_pos(pos - 1);
          victim = link_after(prev);
          if (victim != NIL) node_next[prev] = link_after(victim);
        end
        // unlinked node goes to the front of the free chain
        if (victim != NIL) begin
          res.removed_value = node_val[victim];
          node_next[victim] = (free_head >= NIL) ? NIL : free_head;
          free_head         = victim;
        end
        elem_count--;
      end
    end
    res.list_length = LEN_W'(elem_count);
    return res;
  endfunction

  // Sample at the falling edge: inputs only move at the rising edge
  always @(negedge clk_i) begin : watch
    rsp_t want;
    if (!rst_ni) begin
      // empty list, no freed nodes, nothing owed
      for (int i = 0; i < CAPACITY; i++) begin
        node_val[i]  = '0;
        node_next[i] = 0;
      end
      head_node  = NIL;
      free_head  = NIL;
      fresh_used = 0;
      elem_count = 0;
      list_replies_q.delete();
      outstanding_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) list_replies_q.push_back(apply_list_request(in_req_i));
      if (out_valid_i && out_ready_i) begin
        if (list_replies_q.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, got status %0d len %0d",
                   $time, out_rsp_i.status, out_rsp_i.list_length);
          fail_count_o++;
        end else begin
          want = list_replies_q.pop_front();
          if (out_rsp_i.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_rsp_i.status);
            fail_count_o++;
          end
          if (out_rsp_i.removed_value !== want.removed_value) begin
            $display("%0t: removed_value mismatch, expected %0d, got %0d",
                     $time, want.removed_value, out_rsp_i.removed_value);
            fail_count_o++;
          end
          if (out_rsp_i.list_length !== want.list_length) begin
            $display("%0t: list_length mismatch, expected %0d, got %0d",
                     $time, want.list_length, out_rsp_i.list_length);
            fail_count_o++;
          end
        end
      end
      outstanding_o = list_replies_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the positional linked list: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import plid_pkg::*;

  localparam int ITEMS            = 2000;
  localparam int LONG_HOLD_AT     = 1000;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES     = 150;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_rsp_o;

  int          fail_count;
  int          outstanding;
  int          accepted_count;
  int unsigned list_len;  // element count as seen by the stimulus

  positional_list_insert_delete u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  plid_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_req_i      (in_req_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_rsp_i     (out_rsp_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  // Keep the list length in step so random positions land mostly in range
  function automatic void track_length(input req_t r);
    if (r.req_type == REQ_INSERT) begin
      if (r.position >= 1 && r.position <= list_len + 1 && list_len < CapacityDef) list_len++;
    end else if (r.position >= 1 && r.position <= list_len) begin
      list_len--;
    end
  endfunction

  // One transfer: present, wait for ready seen at the falling edge, leave valid high
  task automatic send_req(input req_t r);
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    track_length(r);
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    accepted_count++;
  endtask

  // Mostly in-range requests with a chosen insert share, some edges and noise
  function automatic req_t next_request(input int unsigned insert_pct);
    req_t        r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 7))
      0:       r.value = 32'h7fff_ffff;
      1:       r.value = 32'h8000_0000;
      2:       r.value = '0;
      3:       r.value = '1;
      default: r.value = $urandom;
    endcase
    if (roll < 8) begin
      r.req_type = 1'($urandom_range(0, 1));
      r.position = POS_W'($urandom_range(0, 127));
    end else begin
      r.req_type = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_DELETE;
      if (r.req_type == REQ_INSERT) begin
        r.position = POS_W'($urandom_range(1, list_len + 1));
      end else if (list_len == 0) begin
        r.position = POS_W'(1);
      end else begin
        r.position = POS_W'($urandom_range(1, list_len));
      end
      // ends of the list and just past them
      if (roll < 18) begin
        case ($urandom_range(0, 3))
          0:       r.position = POS_W'(1);
          1:       r.position = POS_W'(list_len);
          2:       r.position = POS_W'(list_len + 1);
          default: r.position = POS_W'(list_len + 2);
        endcase
      end
    end
    return r;
  endfunction

  // Receiver: segments of always ready, coin-flip ready and sparse ready,
  // plus one long hold-off midway to back the block up
  initial begin : receiver
    int seg_left;
    int mode;
    int period;
    int tick;
    bit long_hold_done;
    out_ready_i    <= 1'b0;
    seg_left       = 0;
    mode           = 0;
    period         = 1;
    tick           = 0;
    long_hold_done = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && accepted_count >= LONG_HOLD_AT) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_done = 1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 2);
          period   = $urandom_range(2, 8);
          seg_left = $urandom_range(20, 400);
        end
        seg_left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          default: begin
            tick++;
            out_ready_i <= (tick % period == 0);
          end
        endcase
      end
    end
  end

  // Reset, directed requests, random bursts, drain and verdict
  initial begin : sender
    int          phase_left;
    int unsigned insert_pct;
    int          burst;
    int          gap;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    in_req_i       <= '0;
    accepted_count = 0;
    list_len       = 0;
    phase_left     = 0;
    insert_pct     = 50;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list errors, head/middle/tail inserts, range edges,
    // tail/middle/head deletes, and reuse of freed nodes
    send_req('{REQ_DELETE, 7'd1,   32'h1234_5678});
    send_req('{REQ_INSERT, 7'd0,   32'h0000_0001});
    send_req('{REQ_INSERT, 7'd2,   32'h0000_0002});
    send_req('{REQ_INSERT, 7'd1,   32'h7fff_ffff});
    send_req('{REQ_INSERT, 7'd2,   32'h8000_0000});
    send_req('{REQ_INSERT, 7'd1,   32'hffff_ffff});
    send_req('{REQ_INSERT, 7'd2,   32'h0000_0000});
    send_req('{REQ_INSERT, 7'd127, 32'hdead_beef});
    send_req('{REQ_INSERT, 7'd6,   32'h0bad_f00d});
    send_req('{REQ_DELETE, 7'd5,   32'h0000_0000});
    send_req('{REQ_DELETE, 7'd0,   32'h0000_0000});
    send_req('{REQ_DELETE, 7'd127, 32'hffff_ffff});
    send_req('{REQ_DELETE, 7'd4,   32'haaaa_aaaa});
    send_req('{REQ_DELETE, 7'd2,   32'h5555_5555});
    send_req('{REQ_DELETE, 7'd1,   32'h0000_0000});
    send_req('{REQ_INSERT, 7'd1,   32'h5555_5555});
    send_req('{REQ_INSERT, 7'd3,   32'haaaa_aaaa});
    send_req('{REQ_INSERT, 7'd2,   32'h0f0f_0f0f});
    send_req('{REQ_DELETE, 7'd4,   32'h0000_0000});
    send_req('{REQ_DELETE, 7'd3,   32'h0000_0000});

    // Random: phases biased to fill, drain or churn the pool
    while (accepted_count < ITEMS) begin
      if (phase_left <= 0) begin
        case ($urandom_range(0, 3))
          0:       insert_pct = 85;
          1:       insert_pct = 15;
          2:       insert_pct = 50;
          default: insert_pct = 65;
        endcase
        phase_left = $urandom_range(60, 250);
      end
      burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
      for (int b = 0; b < burst && accepted_count < ITEMS; b++) begin
        send_req(next_request(insert_pct));
        phase_left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
